>>> design/mkh_pkg.sv
// Shared constants, types and helpers for the MurmurHash2 key hasher.
// No dependencies; used by the controller, datapath and top level.
package mkh_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int unsigned MIX_SHIFT   = 24;
  localparam int unsigned FIN_SHIFT_A = 13;
  localparam int unsigned FIN_SHIFT_B = 15;
  localparam logic [31:0] SEED_RESET  = 32'd5381;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_K2,
    ST_HMIX,
    ST_FIN
  } mkh_state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_WORD_K1,
    OP_WORD_TAIL,
    OP_WORD_EMPTY,
    OP_K2,
    OP_HMIX,
    OP_FIN
  } mkh_op_e;

  typedef struct packed {
    mkh_op_e op;
  } mkh_cmd_t;

  typedef struct packed {
    logic full_word;
    logic empty_word;
  } mkh_status_t;

  function automatic logic [31:0] tail_mask(input logic [1:0] count);
    logic [31:0] m;
    case (count)
      2'd1:    m = 32'h0000_00ff;
      2'd2:    m = 32'h0000_ffff;
      2'd3:    m = 32'h00ff_ffff;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage

>>> design/mkh_ctrl.sv
// Sequencer for the hasher: steps each item through the shared multiplier.
// Depends on mkh_pkg; drives mkh_datapath through a command struct.
module mkh_ctrl
  import mkh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  mkh_status_t status_i,
  output mkh_cmd_t    cmd_o
);

  mkh_state_e state_q, state_d;
  logic       last_q, last_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       fin_fire;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign fin_fire    = (state_q == ST_FIN) && !(out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (status_i.full_word) begin
            state_d = ST_K2;
          end else if (last_word_i) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_K2:   state_d = ST_HMIX;
      ST_HMIX: state_d = last_q ? ST_FIN : ST_IDLE;
      ST_FIN: begin
        if (fin_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (status_i.full_word) begin
            cmd_o.op = OP_WORD_K1;
          end else if (status_i.empty_word) begin
            cmd_o.op = OP_WORD_EMPTY;
          end else begin
            cmd_o.op = OP_WORD_TAIL;
          end
        end
      end
      ST_K2:   cmd_o.op = OP_K2;
      ST_HMIX: cmd_o.op = OP_HMIX;
      ST_FIN: begin
        if (fin_fire) begin
          cmd_o.op = OP_FIN;
        end
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_comb begin
    last_d = accept ? last_word_i : last_q;
    if (fin_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> design/mkh_datapath.sv
// Hash datapath: seed register, running hash, mix temporary, one shared
// constant multiplier and the result register. Depends on mkh_pkg.
module mkh_datapath
  import mkh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        hash_seed_we_i,
  input  logic [31:0] hash_seed_i,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        first_word_i,
  input  logic [31:0] key_length_i,
  input  mkh_cmd_t    cmd_i,
  output mkh_status_t status_o,
  output logic [31:0] hash_value_o
);

  logic [31:0] seed_q;
  logic [31:0] hash_q, hash_d;
  logic [31:0] k_q, k_d;
  logic [31:0] res_q, res_d;
  logic [31:0] h_start;
  logic [31:0] tail_bits;
  logic [31:0] mul_a;
  logic [31:0] product;

  assign status_o.full_word  = valid_bytes_i[2];
  assign status_o.empty_word = (valid_bytes_i == 3'd0);

  assign h_start   = first_word_i ? (seed_q ^ key_length_i) : hash_q;
  assign tail_bits = data_word_i & tail_mask(valid_bytes_i[1:0]);

  always_comb begin
    case (cmd_i.op)
      OP_WORD_K1:   mul_a = data_word_i;
      OP_WORD_TAIL: mul_a = h_start ^ tail_bits;
      OP_K2:        mul_a = k_q ^ (k_q >> MIX_SHIFT);
      OP_FIN:       mul_a = hash_q ^ (hash_q >> FIN_SHIFT_A);
      default:      mul_a = hash_q;
    endcase
  end

  assign product = mul_a * MIX_MUL;

  always_comb begin
    hash_d = hash_q;
    k_d    = k_q;
    res_d  = res_q;
    case (cmd_i.op)
      OP_WORD_K1: begin
        k_d    = product;
        hash_d = h_start;
      end
      OP_WORD_TAIL:  hash_d = product;
      OP_WORD_EMPTY: hash_d = h_start;
      OP_K2:         k_d    = product;
      OP_HMIX:       hash_d = product ^ k_q;
      OP_FIN:        res_d  = product ^ (product >> FIN_SHIFT_B);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_RESET;
      hash_q <= '0;
    end else begin
      if (hash_seed_we_i) begin
        seed_q <= hash_seed_i;
      end
      hash_q <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    res_q <= res_d;
  end

  assign hash_value_o = res_q;

endmodule

>>> design/murmur2_key_hash_top.sv
// Top level of the streaming MurmurHash2 (32-bit) key hasher.
// Depends on mkh_pkg, mkh_ctrl and mkh_datapath.
//
// Keys arrive as 32-bit little-endian words; the word flagged first restarts
// the hash from the seed XOR key length. A full word makes three passes
// through the single 32x32 constant multiplier; a tail word makes one and an
// empty word none. A word flagged last is followed by a finalisation pass,
// after which the hash sits in an output register until taken; the next
// item is accepted while it waits. Input stall is high whenever an item is
// in progress. The seed may be written at any idle time.
module murmur2_key_hash_top
  import mkh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        hash_seed_we_i,
  input  logic [31:0] hash_seed_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        first_word_i,
  input  logic        last_word_i,
  input  logic [31:0] key_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o
);

  mkh_cmd_t    cmd;
  mkh_status_t status;

  mkh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .last_word_i (last_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mkh_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .hash_seed_we_i (hash_seed_we_i),
    .hash_seed_i    (hash_seed_i),
    .data_word_i    (data_word_i),
    .valid_bytes_i  (valid_bytes_i),
    .first_word_i   (first_word_i),
    .key_length_i   (key_length_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .hash_value_o   (hash_value_o)
  );

endmodule
